// ===== design/popq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// popq_pkg
// shared constants and codes for the priority ordered process queue
// ----------------------------------------------------------------------------
package popq_pkg;

  localparam int DEF_QUEUE_DEPTH    = 16;
  localparam int DEF_ID_WIDTH       = 6;
  localparam int DEF_PRIORITY_WIDTH = 8;

  typedef enum logic [1:0] {
    ACT_INSERT      = 2'd0,
    ACT_REMOVE_HEAD = 2'd1,
    ACT_REMOVE_ID   = 2'd2,
    ACT_PEEK        = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_HEAD,
    S_RMV,
    S_PEEK,
    S_RESP
  } ctrl_state_t;

endpackage

// ===== design/popq_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// popq_mem
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module popq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 14,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/popq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// popq_ctrl
// request sequencer: walks the entry store, shifts entries and forms results
// ----------------------------------------------------------------------------
module popq_ctrl #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int ID_WIDTH       = 6,
  parameter int PRIORITY_WIDTH = 8,
  localparam int AW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int EW = ID_WIDTH + PRIORITY_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  popq_pkg::action_t         req_action,
  input  logic [ID_WIDTH-1:0]       req_id,
  input  logic [PRIORITY_WIDTH-1:0] req_prio,
  output logic                      mem_rd_en,
  output logic [AW-1:0]             mem_rd_addr,
  input  logic [EW-1:0]             mem_rd_data,
  output logic                      mem_wr_en,
  output logic [AW-1:0]             mem_wr_addr,
  output logic [EW-1:0]             mem_wr_data,
  output logic                      res_valid,
  input  logic                      res_take,
  output popq_pkg::status_t         res_status,
  output logic [ID_WIDTH-1:0]       res_id,
  output logic [PRIORITY_WIDTH-1:0] res_prio,
  output logic [CW-1:0]             res_count
);

  import popq_pkg::*;

  ctrl_state_t               state, state_next;
  action_t                   action_q, action_q_next;
  logic [ID_WIDTH-1:0]       id_q, id_q_next;
  logic [PRIORITY_WIDTH-1:0] prio_q, prio_q_next;
  logic [CW-1:0]             count, count_next;
  logic [AW-1:0]             ridx, ridx_next;
  logic                      found, found_next;
  status_t                   status_q, status_q_next;
  logic [ID_WIDTH-1:0]       rid, rid_next;
  logic [PRIORITY_WIDTH-1:0] rprio, rprio_next;

  logic [ID_WIDTH-1:0]       rd_id;
  logic [PRIORITY_WIDTH-1:0] rd_prio;
  logic                      last;
  logic                      match;

  assign rd_id   = mem_rd_data[EW-1:PRIORITY_WIDTH];
  assign rd_prio = mem_rd_data[PRIORITY_WIDTH-1:0];
  assign last    = (CW'(ridx) + CW'(1)) == count;
  assign match   = !found && ((action_q == ACT_REMOVE_HEAD) || (rd_id == id_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      found <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    action_q <= action_q_next;
    id_q     <= id_q_next;
    prio_q   <= prio_q_next;
    ridx     <= ridx_next;
    status_q <= status_q_next;
    rid      <= rid_next;
    rprio    <= rprio_next;
  end

  always_comb begin
    state_next    = state;
    action_q_next = action_q;
    id_q_next     = id_q;
    prio_q_next   = prio_q;
    count_next    = count;
    ridx_next     = ridx;
    found_next    = found;
    status_q_next = status_q;
    rid_next      = rid;
    rprio_next    = rprio;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = ridx;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = ridx + AW'(1);
    mem_wr_data   = mem_rd_data;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          action_q_next = req_action;
          id_q_next     = req_id;
          prio_q_next   = req_prio;
          found_next    = 1'b0;
          status_q_next = ST_OK;
          rid_next      = '0;
          rprio_next    = '0;
          if (req_action == ACT_INSERT) begin
            if (count == CW'(QUEUE_DEPTH)) begin
              status_q_next = ST_FULL;
              state_next    = S_RESP;
            end else if (count == '0) begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = '0;
              mem_wr_data = {req_id, req_prio};
              count_next  = count + CW'(1);
              rid_next    = req_id;
              rprio_next  = req_prio;
              state_next  = S_RESP;
            end else begin
              // walk back from the tail
              mem_rd_en   = 1'b1;
              mem_rd_addr = AW'(count - CW'(1));
              ridx_next   = AW'(count - CW'(1));
              state_next  = S_INS;
            end
          end else if (count == '0) begin
            status_q_next = ST_EMPTY;
            state_next    = S_RESP;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
            ridx_next   = '0;
            state_next  = (req_action == ACT_PEEK) ? S_PEEK : S_RMV;
          end
        end
      end

      S_INS: begin
        mem_wr_en = 1'b1;
        if (rd_prio >= prio_q) begin
          mem_wr_data = {id_q, prio_q};
          count_next  = count + CW'(1);
          rid_next    = id_q;
          rprio_next  = prio_q;
          state_next  = S_RESP;
        end else if (ridx == '0) begin
          state_next = S_INS_HEAD;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ridx - AW'(1);
          ridx_next   = ridx - AW'(1);
        end
      end

      S_INS_HEAD: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = '0;
        mem_wr_data = {id_q, prio_q};
        count_next  = count + CW'(1);
        rid_next    = id_q;
        rprio_next  = prio_q;
        state_next  = S_RESP;
      end

      S_PEEK: begin
        rid_next   = rd_id;
        rprio_next = rd_prio;
        state_next = S_RESP;
      end

      S_RMV: begin
        // entries past the removed one move down by one
        if (found) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = ridx - AW'(1);
        end else if (match) begin
          found_next = 1'b1;
          rid_next   = rd_id;
          rprio_next = rd_prio;
        end
        if (last) begin
          if (found || match) begin
            count_next = count - CW'(1);
          end else begin
            status_q_next = ST_NOT_FOUND;
          end
          state_next = S_RESP;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ridx + AW'(1);
          ridx_next   = ridx + AW'(1);
        end
      end

      S_RESP: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req_ready  = (state == S_IDLE);
  assign res_valid  = (state == S_RESP);
  assign res_status = status_q;
  assign res_id     = rid;
  assign res_prio   = rprio;
  assign res_count  = count;

endmodule

// ===== design/priority_ordered_process_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ordered_process_queue_core
// sorted process queue, highest priority first, one result per request
// ----------------------------------------------------------------------------
// Entries live in one synchronous memory in service order. One request is
// worked at a time. Insert walks back from the tail, one entry per cycle,
// moving each lower entry up until its place is found; into an empty queue
// it writes the head directly. Remove head and remove by id walk the whole
// queue once, moving the entries behind the removed one down. Peek reads
// the head only. A remove or peek on an empty queue, or an insert on a full
// one, gives an empty or full status without touching the memory. The
// memory has a single read and a single write port.
// A finished result sits in an output register, so the next request is taken
// while it waits. No clearing pass is needed after reset.
module priority_ordered_process_queue_core #(
  parameter int QUEUE_DEPTH    = popq_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_WIDTH       = popq_pkg::DEF_ID_WIDTH,
  parameter int PRIORITY_WIDTH = popq_pkg::DEF_PRIORITY_WIDTH,
  localparam int CW     = $clog2(QUEUE_DEPTH + 1),
  localparam int IN_DW  = ((ID_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((ID_WIDTH + PRIORITY_WIDTH + CW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_DW-1:0]  s_tdata,   // proc_id, priority_req
  input  logic [1:0]        s_tuser,   // action
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_DW-1:0] m_tdata,   // out_id, out_priority, entry_count
  output logic [1:0]        m_tuser    // status
);

  import popq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int EW = ID_WIDTH + PRIORITY_WIDTH;

  logic                      mem_rd_en;
  logic [AW-1:0]             mem_rd_addr;
  logic [EW-1:0]             mem_rd_data;
  logic                      mem_wr_en;
  logic [AW-1:0]             mem_wr_addr;
  logic [EW-1:0]             mem_wr_data;
  logic                      res_valid;
  logic                      res_take;
  status_t                   res_status;
  logic [ID_WIDTH-1:0]       res_id;
  logic [PRIORITY_WIDTH-1:0] res_prio;
  logic [CW-1:0]             res_count;

  popq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  popq_ctrl #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .ID_WIDTH       (ID_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (s_tvalid),
    .req_ready   (s_tready),
    .req_action  (action_t'(s_tuser)),
    .req_id      (s_tdata[ID_WIDTH-1:0]),
    .req_prio    (s_tdata[ID_WIDTH +: PRIORITY_WIDTH]),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res_status  (res_status),
    .res_id      (res_id),
    .res_prio    (res_prio),
    .res_count   (res_count)
  );

  // output register, loads when empty or being drained
  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= OUT_DW'({res_count, res_prio, res_id});
      m_tuser <= res_status;
    end
  end

endmodule
